/* rtl/core/ttc_pkg.sv */
// Shared types and constants for the trade tape classifier.
// Used by trade_tape_classifier_top; has no dependencies of its own.
`timescale 1ns / 1ps

package ttc_pkg;

  localparam int PRICE_W   = 32;
  localparam int SIZE_W    = 24;
  localparam int COUNT_W   = 32;
  localparam int DELTA_W   = 48;
  localparam int RUN_W     = 16;
  localparam int MEAN_W    = 40;
  localparam int VOL_W     = 40;
  localparam int TRADES_W  = 16;
  localparam int MULT_W    = 8;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 24;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 160;

  // Average update weights in Q16: keep 64881/65536, add 655/65536.
  localparam logic [15:0] KEEP_Q16  = 16'd64881;
  localparam logic [9:0]  ALPHA_Q16 = 10'd655;
  localparam logic [TRADES_W-1:0] ABSORB_TRADES = 16'd5;

  localparam logic [SIZE_W-1:0] INST_SIZE_RESET  = 24'd10000;
  localparam logic [MULT_W-1:0] LARGE_MULT_RESET = 8'd48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INST_SIZE  = 4'd0,
    CFG_LARGE_MULT = 4'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SC_SMALL  = 2'd0,
    SC_MEDIUM = 2'd1,
    SC_LARGE  = 2'd2,
    SC_INST   = 2'd3
  } size_bucket_t;

  // Result of one trade after the state update, before the absorption test.
  typedef struct packed {
    logic [COUNT_W-1:0]        trade_number;
    logic                      aggressor;
    size_bucket_t              size_bucket;
    logic signed [DELTA_W-1:0] net_delta;
    logic [RUN_W-1:0]          up_run;
    logic [RUN_W-1:0]          down_run;
    logic [MEAN_W-1:0]         average_size;
    logic [VOL_W-1:0]          bid_vol;
    logic [TRADES_W-1:0]       bid_trades;
    logic [VOL_W-1:0]          ask_vol;
    logic [TRADES_W-1:0]       ask_trades;
  } mid_t;

endpackage

/* rtl/core/trade_tape_classifier_top.sv */
// Trade tape classifier: aggressor side, size class and running tape statistics.
// Depends on ttc_pkg for types and constants.
`timescale 1ns / 1ps

// Accepts one tick per cycle while in_tready is high and returns one result item
// per trade (ticks with a zero size are quote-only and give no item). Three
// register stages stand between the ports: the input register, a stage where the
// classification and the whole state update happen together, and an output stage
// that runs the absorption test against the updated average. Throughput is one
// item per cycle while out_tready does not stall the output, set by the state
// loop around the average multiplier, which closes within the middle stage.
// Configuration writes are taken at any time with cfg_ready always high, and
// should only be issued while the block holds no item.
module trade_tape_classifier_top
  import ttc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // trade_price[31:0], trade_size[55:32], bid_price[87:56], ask_price[119:88]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // trade_number[31:0], aggressor[32], size_bucket[34:33], large_trade[35],
  // net_delta[83:36], up_run[99:84], down_run[115:100], bid_absorbing[116],
  // ask_absorbing[117], average_size[157:118], zero[159:158]
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_data
);

  localparam logic signed [DELTA_W:0] DELTA_MAX = {2'b00, {(DELTA_W-1){1'b1}}};
  localparam logic signed [DELTA_W:0] DELTA_MIN = {2'b11, {(DELTA_W-1){1'b0}}};

  // Configuration registers.
  logic [SIZE_W-1:0] inst_size_r;
  logic [MULT_W-1:0] large_mult_r;

  // Input stage.
  logic              s1_valid_r;
  logic [PRICE_W-1:0] s1_price_r, s1_bid_r, s1_ask_r;
  logic [SIZE_W-1:0]  s1_size_r;

  // Tape state.
  logic [PRICE_W-1:0]        prev_price_r, prev_price_nxt;
  logic [COUNT_W-1:0]        count_r, count_nxt;
  logic [MEAN_W-1:0]         mean_r, mean_nxt;
  logic signed [DELTA_W-1:0] delta_r, delta_nxt;
  logic [RUN_W-1:0]          up_r, up_nxt, down_r, down_nxt;
  logic [PRICE_W-1:0]        bid_px_r, bid_px_nxt, ask_px_r, ask_px_nxt;
  logic [VOL_W-1:0]          bid_vol_r, bid_vol_nxt, ask_vol_r, ask_vol_nxt;
  logic [TRADES_W-1:0]       bid_n_r, bid_n_nxt, ask_n_r, ask_n_nxt;

  // Middle and output stages.
  logic  s2_valid_r;
  mid_t  s2_r, s2_nxt;
  logic  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic s3_ready, s2_ready, s1_trade, s1_consume, s2_load;

  assign s3_ready   = !out_valid_r || out_tready;
  assign s2_ready   = !s2_valid_r || s3_ready;
  assign s1_trade   = s1_valid_r && (s1_size_r != '0);
  assign s2_load    = s1_trade && s2_ready;
  // A quote-only tick leaves the input stage without touching anything.
  assign s1_consume = s1_valid_r && ((s1_size_r == '0) || s2_ready);
  assign in_tready  = !s1_valid_r || s1_consume;
  assign cfg_ready  = 1'b1;

  // ---------------------------------------------------------------- classify
  logic                 buyer;
  logic [PRICE_W:0]     quote_sum;
  size_bucket_t         cls;
  logic [MEAN_W+MULT_W-1:0] mean_x_mult;
  logic [MEAN_W+1:0]    mean_x3;
  logic [MEAN_W+15:0]   mean_x_keep;
  logic [SIZE_W+9:0]    size_x_alpha;
  logic [MEAN_W+MULT_W-1:0] size_sh20;
  logic [MEAN_W+1:0]    size_sh17;
  logic signed [DELTA_W:0] delta_ext, size_ext, delta_sum;
  logic [VOL_W:0]       bid_vol_sum, ask_vol_sum;
  logic                 has_prev;

  always_comb begin
    has_prev  = (prev_price_r != '0);
    quote_sum = {1'b0, s1_bid_r} + {1'b0, s1_ask_r};
    priority if (s1_price_r >= s1_ask_r) begin
      buyer = 1'b1;
    end else if (s1_price_r <= s1_bid_r) begin
      buyer = 1'b0;
    end else if (has_prev && (s1_price_r != prev_price_r)) begin
      buyer = (s1_price_r > prev_price_r);
    end else begin
      buyer = ({s1_price_r, 1'b0} >= quote_sum);
    end

    mean_x_mult = mean_r * large_mult_r;
    mean_x3     = {2'b00, mean_r} + {1'b0, mean_r, 1'b0};
    size_sh20   = {{(MEAN_W+MULT_W-SIZE_W-20){1'b0}}, s1_size_r, 20'd0};
    size_sh17   = {{(MEAN_W+2-SIZE_W-17){1'b0}}, s1_size_r, 17'd0};
    priority if (s1_size_r >= inst_size_r) begin
      cls = SC_INST;
    end else if (size_sh20 >= mean_x_mult) begin
      cls = SC_LARGE;
    end else if (size_sh17 >= mean_x3) begin
      cls = SC_MEDIUM;
    end else begin
      cls = SC_SMALL;
    end

    count_nxt = count_r + 1'b1;

    delta_ext = {delta_r[DELTA_W-1], delta_r};
    size_ext  = {{(DELTA_W+1-SIZE_W){1'b0}}, s1_size_r};
    delta_sum = buyer ? (delta_ext + size_ext) : (delta_ext - size_ext);
    if (delta_sum > DELTA_MAX) begin
      delta_nxt = DELTA_MAX[DELTA_W-1:0];
    end else if (delta_sum < DELTA_MIN) begin
      delta_nxt = DELTA_MIN[DELTA_W-1:0];
    end else begin
      delta_nxt = delta_sum[DELTA_W-1:0];
    end

    up_nxt   = up_r;
    down_nxt = down_r;
    if (has_prev && (s1_price_r > prev_price_r)) begin
      if (up_r != '1) up_nxt = up_r + 1'b1;
      down_nxt = '0;
    end else if (has_prev && (s1_price_r < prev_price_r)) begin
      if (down_r != '1) down_nxt = down_r + 1'b1;
      up_nxt = '0;
    end

    // The added term is a whole multiple of 2^16, so only the kept part is
    // truncated by the shift.
    mean_x_keep  = mean_r * KEEP_Q16;
    size_x_alpha = s1_size_r * ALPHA_Q16;
    mean_nxt     = mean_x_keep[MEAN_W+15:16] + {{(MEAN_W-SIZE_W-10){1'b0}}, size_x_alpha};

    bid_px_nxt  = bid_px_r;
    bid_vol_nxt = bid_vol_r;
    bid_n_nxt   = bid_n_r;
    ask_px_nxt  = ask_px_r;
    ask_vol_nxt = ask_vol_r;
    ask_n_nxt   = ask_n_r;
    bid_vol_sum = {1'b0, bid_vol_r} + {{(VOL_W+1-SIZE_W){1'b0}}, s1_size_r};
    ask_vol_sum = {1'b0, ask_vol_r} + {{(VOL_W+1-SIZE_W){1'b0}}, s1_size_r};
    if (buyer) begin
      if (ask_px_r == s1_price_r) begin
        ask_vol_nxt = ask_vol_sum[VOL_W] ? '1 : ask_vol_sum[VOL_W-1:0];
        if (ask_n_r != '1) ask_n_nxt = ask_n_r + 1'b1;
      end else begin
        ask_px_nxt  = s1_price_r;
        ask_vol_nxt = {{(VOL_W-SIZE_W){1'b0}}, s1_size_r};
        ask_n_nxt   = TRADES_W'(1);
      end
    end else begin
      if (bid_px_r == s1_price_r) begin
        bid_vol_nxt = bid_vol_sum[VOL_W] ? '1 : bid_vol_sum[VOL_W-1:0];
        if (bid_n_r != '1) bid_n_nxt = bid_n_r + 1'b1;
      end else begin
        bid_px_nxt  = s1_price_r;
        bid_vol_nxt = {{(VOL_W-SIZE_W){1'b0}}, s1_size_r};
        bid_n_nxt   = TRADES_W'(1);
      end
    end

    prev_price_nxt = s1_price_r;

    s2_nxt.trade_number = count_nxt;
    s2_nxt.aggressor    = buyer;
    s2_nxt.size_bucket  = cls;
    s2_nxt.net_delta    = delta_nxt;
    s2_nxt.up_run       = up_nxt;
    s2_nxt.down_run     = down_nxt;
    s2_nxt.average_size = mean_nxt;
    s2_nxt.bid_vol      = bid_vol_nxt;
    s2_nxt.bid_trades   = bid_n_nxt;
    s2_nxt.ask_vol      = ask_vol_nxt;
    s2_nxt.ask_trades   = ask_n_nxt;
  end

  // --------------------------------------------------------------- absorption
  logic [MEAN_W+3:0]  mean_x10;
  logic [VOL_W+15:0]  bid_vol_sh, ask_vol_sh;
  logic               bid_abs, ask_abs;

  always_comb begin
    mean_x10   = {1'b0, s2_r.average_size, 3'b000} + {3'b000, s2_r.average_size, 1'b0};
    bid_vol_sh = {s2_r.bid_vol, 16'd0};
    ask_vol_sh = {s2_r.ask_vol, 16'd0};
    bid_abs = (bid_vol_sh > {{(VOL_W-MEAN_W+12){1'b0}}, mean_x10}) &&
              (s2_r.bid_trades > ABSORB_TRADES);
    ask_abs = (ask_vol_sh > {{(VOL_W-MEAN_W+12){1'b0}}, mean_x10}) &&
              (s2_r.ask_trades > ABSORB_TRADES);
    out_data_nxt = {2'b00, s2_r.average_size, ask_abs, bid_abs, s2_r.down_run,
                    s2_r.up_run, s2_r.net_delta, s2_r.size_bucket[1],
                    s2_r.size_bucket, s2_r.aggressor, s2_r.trade_number};
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inst_size_r  <= INST_SIZE_RESET;
      large_mult_r <= LARGE_MULT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_INST_SIZE)  inst_size_r  <= cfg_data;
      if (cfg_index == CFG_LARGE_MULT) large_mult_r <= cfg_data[MULT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (s2_ready)  s2_valid_r <= s1_trade;
      if (s3_ready)  out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_price_r <= in_tdata[31:0];
      s1_size_r  <= in_tdata[55:32];
      s1_bid_r   <= in_tdata[87:56];
      s1_ask_r   <= in_tdata[119:88];
    end
    if (s2_load) s2_r <= s2_nxt;
    if (s3_ready && s2_valid_r) out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_price_r <= '0;
      count_r      <= '0;
      mean_r       <= '0;
      delta_r      <= '0;
      up_r         <= '0;
      down_r       <= '0;
      bid_px_r     <= '0;
      bid_vol_r    <= '0;
      bid_n_r      <= '0;
      ask_px_r     <= '0;
      ask_vol_r    <= '0;
      ask_n_r      <= '0;
    end else if (s2_load) begin
      prev_price_r <= prev_price_nxt;
      count_r      <= count_nxt;
      mean_r       <= mean_nxt;
      delta_r      <= delta_nxt;
      up_r         <= up_nxt;
      down_r       <= down_nxt;
      bid_px_r     <= bid_px_nxt;
      bid_vol_r    <= bid_vol_nxt;
      bid_n_r      <= bid_n_nxt;
      ask_px_r     <= ask_px_nxt;
      ask_vol_r    <= ask_vol_nxt;
      ask_n_r      <= ask_n_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // --------------------------------------------------------------- assertions
  a_runs_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (up_r == '0) || (down_r == '0))
    else $error("up and down run counts are both nonzero");

  a_bid_track_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (bid_n_r == '0) == (bid_vol_r == '0))
    else $error("bid tracker count and volume disagree");

  a_ask_track_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (ask_n_r == '0) == (ask_vol_r == '0))
    else $error("ask tracker count and volume disagree");

  a_quote_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && (s1_size_r == '0)) |=> $stable(count_r))
    else $error("quote-only tick changed the trade count");

endmodule

/* sim/trade_tape_checker.sv */
// Scoreboard for the trade tape classifier: watches the tick, result and register channels.
// Predicts each trade result from its own copy of the tape state and compares it field by field.
// Depends on ttc_pkg for widths, register indexes and the size class codes.
`timescale 1ns / 1ps

module trade_tape_checker
  import ttc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_data,
  output int unsigned           mismatch_count,
  output int unsigned           trades_pending
);

  localparam int     ABSORB_AVERAGES = 10;
  localparam longint NET_MAX         = 64'sd140737488355327;
  localparam longint NET_MIN         = -64'sd140737488355328;

  typedef struct packed {
    logic [PRICE_W-1:0] ask;
    logic [PRICE_W-1:0] bid;
    logic [SIZE_W-1:0]  size;
    logic [PRICE_W-1:0] price;
  } tick_t;

  // Mirrors the bit layout of out_tdata, top bits first.
  typedef struct packed {
    logic [1:0]                pad;
    logic [MEAN_W-1:0]         average_size;
    logic                      ask_absorbing;
    logic                      bid_absorbing;
    logic [RUN_W-1:0]          down_run;
    logic [RUN_W-1:0]          up_run;
    logic signed [DELTA_W-1:0] net_delta;
    logic                      large_trade;
    size_bucket_t              size_bucket;
    logic                      aggressor;
    logic [COUNT_W-1:0]        trade_number;
  } tape_result_t;

  typedef struct packed {
    logic [PRICE_W-1:0]  price;
    logic [VOL_W-1:0]    volume;
    logic [TRADES_W-1:0] trades;
  } level_track_t;

  logic [SIZE_W-1:0]  inst_thresh;
  logic [MULT_W-1:0]  big_mult;
  logic [PRICE_W-1:0] last_price;
  logic [COUNT_W-1:0] trade_seq;
  logic [MEAN_W-1:0]  avg_q16;
  longint             net_total;
  logic [RUN_W-1:0]   rise_cnt;
  logic [RUN_W-1:0]   fall_cnt;
  level_track_t       bid_level;
  level_track_t       ask_level;
  tape_result_t       expected_tape[$];
  int unsigned        miss_total = 0;

  task automatic report_mismatch(input string msg);
    miss_total++;
    $display("%0t checker: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got_v,
                             input logic [63:0] want_v, input logic [COUNT_W-1:0] seq);
    if (got_v !== want_v)
      report_mismatch($sformatf("trade %0d %s: got 0x%0h, expected 0x%0h",
                                seq, name, got_v, want_v));
  endtask

  function automatic level_track_t add_to_level(level_track_t lvl, logic [PRICE_W-1:0] price,
                                                logic [SIZE_W-1:0] size);
    logic [VOL_W:0] vol_sum;
    vol_sum = {1'b0, lvl.volume} + (VOL_W+1)'(size);
    if (lvl.price == price) begin
      lvl.volume = vol_sum[VOL_W] ? '1 : vol_sum[VOL_W-1:0];
      if (lvl.trades != '1) lvl.trades = lvl.trades + 1'b1;
    end else begin
      lvl.price  = price;
      lvl.volume = VOL_W'(size);
      lvl.trades = TRADES_W'(1);
    end
    return lvl;
  endfunction

  function automatic logic level_absorbing(level_track_t lvl, logic [MEAN_W-1:0] avg);
    return ((64'(lvl.volume) << 16) > 64'(avg) * 64'(ABSORB_AVERAGES)) &&
           (lvl.trades > ABSORB_TRADES);
  endfunction

  // Classifies one trade and advances the tape state exactly as the block does.
  task automatic classify_trade(input tick_t t, output tape_result_t r);
    logic         buyer;
    size_bucket_t cls;
    longint       sz;
    sz = longint'({40'd0, t.size});

    if (t.price >= t.ask) buyer = 1'b1;
    else if (t.price <= t.bid) buyer = 1'b0;
    else if (last_price != 0 && t.price != last_price) buyer = t.price > last_price;
    else buyer = (64'(t.price) << 1) >= 64'(t.bid) + 64'(t.ask);

    // The size is classed against the average from before this trade.
    if (t.size >= inst_thresh) cls = SC_INST;
    else if ((64'(t.size) << 20) >= 64'(avg_q16) * 64'(big_mult)) cls = SC_LARGE;
    else if ((64'(t.size) << 17) >= 64'(avg_q16) * 64'd3) cls = SC_MEDIUM;
    else cls = SC_SMALL;

    trade_seq = trade_seq + 1'b1;

    if (buyer) net_total = (net_total > NET_MAX - sz) ? NET_MAX : net_total + sz;
    else net_total = (net_total < NET_MIN + sz) ? NET_MIN : net_total - sz;

    if (last_price != 0) begin
      if (t.price > last_price) begin
        if (rise_cnt != '1) rise_cnt = rise_cnt + 1'b1;
        fall_cnt = '0;
      end else if (t.price < last_price) begin
        if (fall_cnt != '1) fall_cnt = fall_cnt + 1'b1;
        rise_cnt = '0;
      end
    end

    avg_q16 = MEAN_W'((64'(avg_q16) * 64'(KEEP_Q16) +
                       (64'(t.size) << 16) * 64'(ALPHA_Q16)) >> 16);

    if (buyer) ask_level = add_to_level(ask_level, t.price, t.size);
    else bid_level = add_to_level(bid_level, t.price, t.size);

    last_price = t.price;

    r = '0;
    r.trade_number  = trade_seq;
    r.aggressor     = buyer;
    r.size_bucket   = cls;
    r.large_trade   = (cls == SC_LARGE) || (cls == SC_INST);
    r.net_delta     = net_total[DELTA_W-1:0];
    r.up_run        = rise_cnt;
    r.down_run      = fall_cnt;
    r.bid_absorbing = level_absorbing(bid_level, avg_q16);
    r.ask_absorbing = level_absorbing(ask_level, avg_q16);
    r.average_size  = avg_q16;
  endtask

  always @(posedge clk) begin
    tape_result_t got;
    tape_result_t want;
    tick_t        tick;
    if (!rst_n) begin
      inst_thresh = INST_SIZE_RESET;
      big_mult    = LARGE_MULT_RESET;
      last_price  = '0;
      trade_seq   = '0;
      avg_q16     = '0;
      net_total   = 0;
      rise_cnt    = '0;
      fall_cnt    = '0;
      bid_level   = '0;
      ask_level   = '0;
      expected_tape.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = tape_result_t'(out_tdata);
        if (expected_tape.size() == 0) begin
          report_mismatch($sformatf("result item for trade %0d with no trade outstanding",
                                    got.trade_number));
        end else begin
          want = expected_tape[0];
          expected_tape.delete(0);
          check_field("trade_number", got.trade_number, want.trade_number, want.trade_number);
          check_field("aggressor", got.aggressor, want.aggressor, want.trade_number);
          check_field("size_bucket", got.size_bucket, want.size_bucket, want.trade_number);
          check_field("large_trade", got.large_trade, want.large_trade, want.trade_number);
          check_field("net_delta", got.net_delta, want.net_delta, want.trade_number);
          check_field("up_run", got.up_run, want.up_run, want.trade_number);
          check_field("down_run", got.down_run, want.down_run, want.trade_number);
          check_field("bid_absorbing", got.bid_absorbing, want.bid_absorbing,
                      want.trade_number);
          check_field("ask_absorbing", got.ask_absorbing, want.ask_absorbing,
                      want.trade_number);
          check_field("average_size", got.average_size, want.average_size, want.trade_number);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_INST_SIZE:  inst_thresh = cfg_data;
          CFG_LARGE_MULT: big_mult = cfg_data[MULT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        tick = tick_t'(in_tdata);
        // A zero size is a quote update: no result and no state change.
        if (tick.size != '0) begin
          classify_trade(tick, want);
          expected_tape.insert(expected_tape.size(), want);
        end
      end
    end
    mismatch_count <= miss_total;
    trades_pending <= expected_tape.size();
  end

endmodule

/* sim/tb_top.sv */
// Top of the trade tape classifier testbench: clock, reset, tick and register stimulus.
// Instantiates trade_tape_classifier_top and trade_tape_checker; depends on ttc_pkg.
`timescale 1ns / 1ps

module tb_top;
  import ttc_pkg::*;

  localparam int STALL_LIMIT   = 1000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_TRADES = 420;
  localparam int SEGMENTS      = 4;
  localparam int SAT_RUN       = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'd15;
  localparam logic [PRICE_W-1:0]   PRICE_MAX      = '1;
  localparam logic [SIZE_W-1:0]    SIZE_MAX       = '1;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DAT_W-1:0]  cfg_data   = '0;

  int unsigned        mismatch_count;
  int unsigned        trades_pending;
  int unsigned        send_idle_pct = 29;
  int unsigned        recv_idle_pct = 53;
  int unsigned        stall_cycles  = 0;
  logic [SIZE_W-1:0]  inst_now      = INST_SIZE_RESET;
  logic [PRICE_W-1:0] mid_price     = 32'd10000;
  logic [PRICE_W-1:0] last_px       = 32'd10000;
  logic [PRICE_W-1:0] burst_px      = '0;
  logic               burst_buy     = 1'b0;
  int unsigned        burst_left    = 0;

  always #5 clk = ~clk;

  trade_tape_classifier_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  trade_tape_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .trades_pending (trades_pending)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_tick(input logic [PRICE_W-1:0] price, input logic [SIZE_W-1:0] size,
                           input logic [PRICE_W-1:0] bid, input logic [PRICE_W-1:0] ask);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ask, bid, size, price};
    do @(posedge clk); while (!in_tready);
  endtask

  // Quote-only ticks can still be in the pipe when the last result arrives,
  // so a few extra cycles follow the empty scoreboard.
  task automatic settle_block();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (trades_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(input logic [SIZE_W-1:0] inst, input logic [MULT_W-1:0] mult);
    settle_block();
    write_reg(CFG_UNUSED_IDX, CFG_DAT_W'($urandom));
    write_reg(CFG_INST_SIZE, inst);
    write_reg(CFG_LARGE_MULT, CFG_DAT_W'(mult));
    cfg_valid <= 1'b0;
    inst_now = inst;
  endtask

  // Mostly orderly quotes around a drifting mid, with bursts hitting one level
  // to build up the absorption trackers, plus quote updates and wild ticks.
  task automatic send_market_tick(output bit traded);
    logic [PRICE_W-1:0] price;
    logic [PRICE_W-1:0] bid;
    logic [PRICE_W-1:0] ask;
    logic [PRICE_W-1:0] spread;
    logic [SIZE_W-1:0]  size;
    int unsigned        roll;
    roll   = $urandom_range(99);
    spread = PRICE_W'($urandom_range(4, 1));
    case ($urandom_range(9))
      0:       size = SIZE_W'($urandom);
      1:       size = inst_now;
      2:       size = SIZE_W'($urandom_range(20000, 2000));
      default: size = SIZE_W'($urandom_range(1500, 1));
    endcase
    if (burst_left != 0) begin
      burst_left--;
      price = burst_px;
      bid   = burst_buy ? burst_px - spread : burst_px;
      ask   = burst_buy ? burst_px : burst_px + spread;
    end else begin
      bid = mid_price - spread;
      ask = mid_price + spread;
      case ($urandom_range(4))
        0:       price = bid;
        1:       price = ask;
        2:       price = last_px;
        default: price = bid + PRICE_W'($urandom_range(2 * spread));
      endcase
      if ($urandom_range(9) == 0) begin
        burst_left = $urandom_range(12, 6);
        burst_buy  = 1'($urandom_range(1));
        burst_px   = mid_price;
      end
    end
    if (roll < 8) begin
      size  = '0;
      price = $urandom;
      bid   = $urandom;
      ask   = $urandom;
    end else if (roll < 16) begin
      price = $urandom;
      bid   = $urandom;
      ask   = $urandom;
    end
    traded = (size != '0);
    send_tick(price, size, bid, ask);
    if (traded) last_px = price;
    mid_price = mid_price + PRICE_W'($urandom_range(4)) - PRICE_W'(2);
  endtask

  initial begin
    bit          traded;
    int unsigned trades_done;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks under the reset register values.
    send_tick(PRICE_MAX, '0, '0, PRICE_MAX);          // quote update only
    send_tick(32'd1000, 24'd100, 32'd990, 32'd1010);  // first trade, decided by the midpoint
    send_tick(32'd1010, 24'd10000, 32'd990, 32'd1010);
    send_tick(32'd990, 24'd1, 32'd990, 32'd1010);
    send_tick(32'd1000, 24'd50, 32'd990, 32'd1010);   // uptick inside the spread
    send_tick(32'd1000, 24'd400, 32'd995, 32'd1010);  // unchanged price
    send_tick(32'd1000, 24'd200, 32'd1005, 32'd995);  // crossed quotes
    for (int i = 0; i < 6; i++) send_tick(32'd500, 24'd5000, 32'd500, 32'd510);
    for (int i = 0; i < 6; i++) send_tick(32'd510, 24'd5000, 32'd500, 32'd510);
    send_tick(PRICE_MAX, SIZE_MAX, PRICE_MAX - 1, PRICE_MAX);
    send_tick('0, 24'd300, '0, 32'd5);                // trade at price zero
    send_tick(32'd50, 24'd20, 32'd40, 32'd60);        // no prior trade again
    send_tick(32'd7, 24'd1, 32'd3, 32'd20);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: load_settings(24'd1, 8'd16);
        1: begin
          send_idle_pct <= 53;
          recv_idle_pct <= 29;
          load_settings(SIZE_MAX, 8'd255);
        end
        2: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
          load_settings('0, '0);
        end
        default: load_settings(SIZE_W'($urandom_range(5000, 500)),
                               MULT_W'($urandom_range(80, 16)));
      endcase
      trades_done = 0;
      while (trades_done < RANDOM_TRADES / SEGMENTS) begin
        send_market_tick(traded);
        if (traded) trades_done++;
      end
    end

    // Runs of upticks and of maximum-size trades at one level, which build up
    // the run counter and a tracker with large volumes.
    for (int i = 0; i < SAT_RUN; i++)
      send_tick(PRICE_W'(100 + i), SIZE_MAX, PRICE_W'(99 + i), PRICE_W'(101 + i));
    for (int i = 0; i < SAT_RUN; i++)
      send_tick(32'd5000, SIZE_MAX, 32'd5000, 32'd5001);

    settle_block();
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
